// ===== rtl/stq_pkg.sv =====
// Package for the sorted timer event queue: entry and cell control types,
// operation and result codes, and default sizes. No dependencies.
package stq_pkg;

   localparam int QueueDepth   = 16;
   localparam int MaxPops      = 16;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [31:0] TicksPerSecondReset = 32'd19200000;

   localparam logic [1:0] OpHold   = 2'd0;
   localparam logic [1:0] OpInsert = 2'd1;
   localparam logic [1:0] OpPop    = 2'd2;

   localparam logic [1:0] KindFired    = 2'd0;
   localparam logic [1:0] KindAdded    = 2'd1;
   localparam logic [1:0] KindRejected = 2'd2;
   localparam logic [1:0] KindNone     = 2'd3;

   localparam logic CmdAdd       = 1'b0;
   localparam logic CmdInterrupt = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [63:0] expiry;
      logic [15:0] tag;
   } entry_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] expiry;
      logic [15:0] tag;
   } cell_ctrl_type;

endpackage

// ===== rtl/stq_req_if.sv =====
// Request channel interface of the sorted timer event queue.
// Carries valid, ready and the request payload; no dependencies.
interface stq_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] event_tag;
   logic [31:0] duration_seconds;
   logic [63:0] now_tick;

   modport source (output valid, output command, output event_tag,
                   output duration_seconds, output now_tick, input ready);
   modport sink   (input valid, input command, input event_tag,
                   input duration_seconds, input now_tick, output ready);
endinterface

// ===== rtl/stq_rsp_if.sv =====
// Response channel interface of the sorted timer event queue.
// Carries valid, ready and the response payload; no dependencies.
interface stq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] fired_tag;
   logic [63:0] next_deadline;
   logic        armed;
   logic        last;

   modport source (output valid, output kind, output fired_tag,
                   output next_deadline, output armed, output last, input ready);
   modport sink   (input valid, input kind, input fired_tag,
                   input next_deadline, input armed, input last, output ready);
endinterface

// ===== rtl/sorted_timer_event_queue_unit.sv =====
// Sorted timer event queue. An add transaction passes through these steps from acceptance to its
// response: register the request, the 32 by 32 multiply, the 64-bit add, insert into the cell
// row and load the response register. An interrupt transaction pops and then responds for each
// fired event, or gives a single response when nothing has expired; the cell row shifts by one
// entry on each pop. A new request is taken only after the last response of the previous one
// has been loaded, and a response waits in its register until the sink takes it. The
// ticks_per_second register is at byte address 0.
module sorted_timer_event_queue_unit #(
   parameter int QUEUE_DEPTH = stq_pkg::QueueDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   stq_req_if.sink                           req_chan,
   stq_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [stq_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [stq_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [stq_pkg::CsrDataWidth-1:0]  prdata,
   output logic                              pready
);

   localparam int PopWidth = $clog2(stq_pkg::MaxPops + 1);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StMul   = 3'd1;
   localparam logic [2:0] StAdd   = 3'd2;
   localparam logic [2:0] StIns   = 3'd3;
   localparam logic [2:0] StCheck = 3'd4;
   localparam logic [2:0] StEmit  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [31:0]         tps_ff;
   logic                cmd_ff;
   logic [15:0]         tag_ff;
   logic [31:0]         dur_ff;
   logic [63:0]         now_ff;
   logic [63:0]         prod_ff;
   logic [63:0]         exp_ff;
   logic [1:0]          kind_ff, kind_in;
   logic [15:0]         res_tag_ff, res_tag_in;
   logic [PopWidth-1:0] pops_ff, pops_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff;
   logic [15:0]         rsp_tag_ff;
   logic [63:0]         rsp_deadline_ff;
   logic                rsp_armed_ff;
   logic                rsp_last_ff;
   logic                load_rsp;
   logic                rsp_last_in;

   stq_pkg::cell_ctrl_type ctrl;
   stq_pkg::entry_type     head;
   logic                   full;
   logic                   can_pop;
   logic                   out_free;
   logic                   accept;
   logic                   csr_write;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata    = (paddr[2] == 1'b0) ? tps_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= stq_pkg::TicksPerSecondReset;
      end else if (csr_write) begin
         tps_ff <= pwdata;
      end
   end

   stq_chain #(
      .Depth (QUEUE_DEPTH)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .head  (head),
      .full  (full)
   );

   assign req_chan.ready = (state_ff == StIdle);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign can_pop        = head.valid && (head.expiry <= now_ff)
                           && (pops_ff < PopWidth'(stq_pkg::MaxPops));

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      res_tag_in  = res_tag_ff;
      pops_in     = pops_ff;
      ctrl.op     = stq_pkg::OpHold;
      ctrl.expiry = exp_ff;
      ctrl.tag    = tag_ff;
      load_rsp    = 1'b0;
      rsp_last_in = 1'b1;
      unique case (state_ff)
         StIdle: begin
            pops_in = '0;
            if (accept) begin
               state_in = (req_chan.command == stq_pkg::CmdAdd) ? StMul : StCheck;
            end
         end
         StMul: begin
            state_in = StAdd;
         end
         StAdd: begin
            state_in = StIns;
         end
         StIns: begin
            if (full) begin
               kind_in    = stq_pkg::KindRejected;
               res_tag_in = '0;
            end else begin
               ctrl.op    = stq_pkg::OpInsert;
               kind_in    = stq_pkg::KindAdded;
               res_tag_in = tag_ff;
            end
            state_in = StEmit;
         end
         StCheck: begin
            if (can_pop) begin
               ctrl.op    = stq_pkg::OpPop;
               kind_in    = stq_pkg::KindFired;
               res_tag_in = head.tag;
               pops_in    = pops_ff + PopWidth'(1);
            end else begin
               kind_in    = stq_pkg::KindNone;
               res_tag_in = '0;
            end
            state_in = StEmit;
         end
         StEmit: begin
            rsp_last_in = (kind_ff != stq_pkg::KindFired) || !can_pop;
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = rsp_last_in ? StIdle : StCheck;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         pops_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pops_ff      <= pops_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.command;
         tag_ff <= req_chan.event_tag;
         dur_ff <= req_chan.duration_seconds;
         now_ff <= req_chan.now_tick;
      end
      prod_ff    <= {32'd0, tps_ff} * {32'd0, dur_ff};
      exp_ff     <= prod_ff + now_ff;
      kind_ff    <= kind_in;
      res_tag_ff <= res_tag_in;
      if (load_rsp) begin
         rsp_kind_ff     <= kind_ff;
         rsp_tag_ff      <= res_tag_ff;
         rsp_deadline_ff <= head.valid ? head.expiry : 64'd0;
         rsp_armed_ff    <= head.valid;
         rsp_last_ff     <= rsp_last_in || (cmd_ff == stq_pkg::CmdAdd);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.fired_tag     = rsp_tag_ff;
   assign rsp_chan.next_deadline = rsp_deadline_ff;
   assign rsp_chan.armed         = rsp_armed_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

// ===== rtl/stq_cell.sv =====
// One cell of the sorted queue: holds one entry and trades it with its neighbors.
// Depends on stq_pkg.
module stq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  stq_pkg::cell_ctrl_type ctrl,
   input  stq_pkg::entry_type     left_entry,
   input  logic                   left_moves,
   input  stq_pkg::entry_type     right_entry,
   output stq_pkg::entry_type     entry,
   output logic                   moves
);

   logic        valid_ff, valid_in;
   logic [63:0] expiry_ff, expiry_in;
   logic [15:0] tag_ff, tag_in;

   // A cell moves on insert when it is empty or holds a later expiry.
   assign moves = !valid_ff || (expiry_ff > ctrl.expiry);

   assign entry.valid  = valid_ff;
   assign entry.expiry = expiry_ff;
   assign entry.tag    = tag_ff;

   always_comb begin
      valid_in  = valid_ff;
      expiry_in = expiry_ff;
      tag_in    = tag_ff;
      unique case (ctrl.op)
         stq_pkg::OpInsert: begin
            if (moves) begin
               if (left_moves) begin
                  valid_in  = left_entry.valid;
                  expiry_in = left_entry.expiry;
                  tag_in    = left_entry.tag;
               end else begin
                  valid_in  = 1'b1;
                  expiry_in = ctrl.expiry;
                  tag_in    = ctrl.tag;
               end
            end
         end
         stq_pkg::OpPop: begin
            valid_in  = right_entry.valid;
            expiry_in = right_entry.expiry;
            tag_in    = right_entry.tag;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      expiry_ff <= expiry_in;
      tag_ff    <= tag_in;
   end

endmodule

// ===== rtl/stq_chain.sv =====
// Row of queue cells kept sorted by expiry, head at cell zero.
// Depends on stq_pkg and stq_cell.
module stq_chain #(
   parameter int Depth = stq_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stq_pkg::cell_ctrl_type ctrl,
   output stq_pkg::entry_type     head,
   output logic                   full
);

   stq_pkg::entry_type entries [Depth];
   logic               moves   [Depth];
   stq_pkg::entry_type empty_entry;

   assign empty_entry = '0;

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      stq_pkg::entry_type left_entry;
      stq_pkg::entry_type right_entry;
      logic               left_moves;

      if (i == 0) begin : g_first
         assign left_entry = empty_entry;
         assign left_moves = 1'b0;
      end else begin : g_inner
         assign left_entry = entries[i-1];
         assign left_moves = moves[i-1];
      end

      if (i == Depth - 1) begin : g_last
         assign right_entry = empty_entry;
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_moves  (left_moves),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .moves       (moves[i])
      );
   end

   assign head = entries[0];
   assign full = entries[Depth-1].valid;

endmodule

// ===== tb/sorted_timer_event_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sorted timer event queue: watches the request, response and register
// traffic, predicts every response and compares it field by field.
// Depends on stq_pkg and the stq_req_if and stq_rsp_if interfaces.
module sorted_timer_event_queue_checker #(
   parameter logic [stq_pkg::CsrAddrWidth-1:0] RATE_ADDR = '0
) (
   input  logic                             clock,
   input  logic                             reset,
   stq_req_if                               req_mon,
   stq_rsp_if                               rsp_mon,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic                             pready,
   input  logic [stq_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [stq_pkg::CsrDataWidth-1:0] pwdata,
   output int                               error_count,
   output int                               pending_count
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] tag;
      logic [63:0] deadline;
      logic        armed;
      logic        last;
   } timer_report_type;

   logic [31:0]      rate;
   logic [63:0]      deadline_mem [stq_pkg::QueueDepth];
   logic [15:0]      handle_mem [stq_pkg::QueueDepth];
   int               held;
   timer_report_type reports_due [$];
   int               mismatches = 0;
   int               outstanding = 0;

   assign error_count   = mismatches;
   assign pending_count = outstanding;

   function automatic void note_report(input logic [1:0] kind, input logic [15:0] tag,
                                       input logic last);
      timer_report_type report;
      report.kind     = kind;
      report.tag      = tag;
      report.deadline = (held > 0) ? deadline_mem[0] : 64'd0;
      report.armed    = (held > 0);
      report.last     = last;
      reports_due.push_back(report);
   endfunction

   function automatic void schedule_or_expire(input logic cmd, input logic [15:0] tag,
                                              input logic [31:0] dur, input logic [63:0] now);
      logic [63:0]      expiry;
      logic [15:0]      gone_tag;
      int               slot;
      int               popped;
      int               i;
      timer_report_type tail;
      if (cmd == stq_pkg::CmdAdd) begin
         expiry = {32'd0, rate} * {32'd0, dur} + now;
         if (held >= stq_pkg::QueueDepth) begin
            note_report(stq_pkg::KindRejected, 16'd0, 1'b1);
         end else begin
            slot = 0;
            while (slot < held && deadline_mem[slot] <= expiry) slot++;
            for (i = held; i > slot; i--) begin
               deadline_mem[i] = deadline_mem[i-1];
               handle_mem[i]   = handle_mem[i-1];
            end
            deadline_mem[slot] = expiry;
            handle_mem[slot]   = tag;
            held++;
            note_report(stq_pkg::KindAdded, tag, 1'b1);
         end
      end else begin
         popped = 0;
         while (popped < stq_pkg::MaxPops && held > 0 && deadline_mem[0] <= now) begin
            gone_tag = handle_mem[0];
            for (i = 1; i < held; i++) begin
               deadline_mem[i-1] = deadline_mem[i];
               handle_mem[i-1]   = handle_mem[i];
            end
            held--;
            note_report(stq_pkg::KindFired, gone_tag, 1'b0);
            popped++;
         end
         if (popped == 0) begin
            note_report(stq_pkg::KindNone, 16'd0, 1'b1);
         end else begin
            tail = reports_due.pop_back();
            tail.last = 1'b1;
            reports_due.push_back(tail);
         end
      end
   endfunction

   function automatic void compare_report(input timer_report_type want);
      if (want.kind !== rsp_mon.kind) begin
         $display("%0t: kind expected %0d, got %0d", $time, want.kind, rsp_mon.kind);
         mismatches++;
      end
      if (want.tag !== rsp_mon.fired_tag) begin
         $display("%0t: fired_tag expected %h, got %h", $time, want.tag, rsp_mon.fired_tag);
         mismatches++;
      end
      if (want.deadline !== rsp_mon.next_deadline) begin
         $display("%0t: next_deadline expected %h, got %h", $time, want.deadline,
                  rsp_mon.next_deadline);
         mismatches++;
      end
      if (want.armed !== rsp_mon.armed) begin
         $display("%0t: armed expected %b, got %b", $time, want.armed, rsp_mon.armed);
         mismatches++;
      end
      if (want.last !== rsp_mon.last) begin
         $display("%0t: last expected %b, got %b", $time, want.last, rsp_mon.last);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rate = stq_pkg::TicksPerSecondReset;
         held = 0;
         reports_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == RATE_ADDR) rate = pwdata;
         if (req_mon.valid && req_mon.ready) begin
            schedule_or_expire(req_mon.command, req_mon.event_tag, req_mon.duration_seconds,
                               req_mon.now_tick);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reports_due.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got kind %0d tag %h",
                        $time, rsp_mon.kind, rsp_mon.fired_tag);
               mismatches++;
            end else begin
               compare_report(reports_due.pop_front());
            end
         end
      end
      outstanding = reports_due.size();
   end

endmodule

// ===== tb/sorted_timer_event_queue_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the sorted timer event queue test: drives requests, register writes and response
// back-pressure, and reports the verdict. Depends on stq_pkg, the channel interfaces, the
// block and sorted_timer_event_queue_checker.
module sorted_timer_event_queue_unit_test;

   localparam logic [stq_pkg::CsrAddrWidth-1:0] RateAddr  = 'd0;
   localparam logic [stq_pkg::CsrAddrWidth-1:0] SpareAddr = 'd4;
   localparam int HoldOffCycles = 300;
   localparam int CycleLimit    = 400000;
   localparam int PhaseItems    = 75;

   logic                             clock;
   logic                             reset;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [stq_pkg::CsrAddrWidth-1:0] paddr;
   logic [stq_pkg::CsrDataWidth-1:0] pwdata;
   logic [stq_pkg::CsrDataWidth-1:0] prdata;
   logic                             pready;
   int                               failures;
   int                               awaited;
   int                               cycle_count = 0;
   int                               responses_seen = 0;
   int                               adds_sent = 0;
   int                               interrupts_sent = 0;
   int                               rates_used = 0;
   bit                               steady = 0;
   bit                               hold_off_go = 0;
   logic [63:0]                      timeline;

   stq_req_if req_chan ();
   stq_rsp_if rsp_chan ();

   sorted_timer_event_queue_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   sorted_timer_event_queue_checker #(
      .RATE_ADDR (RateAddr)
   ) queue_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .error_count   (failures),
      .pending_count (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_chan.valid && rsp_chan.ready) responses_seen++;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      bit hold_off_done;
      hold_off_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   task automatic send_request(input logic cmd, input logic [15:0] tag,
                               input logic [31:0] dur, input logic [63:0] now);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.command          <= cmd;
      req_chan.event_tag        <= tag;
      req_chan.duration_seconds <= dur;
      req_chan.now_tick         <= now;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      if (cmd == stq_pkg::CmdAdd) adds_sent++;
      else interrupts_sent++;
   endtask

   task automatic write_csr(input logic [stq_pkg::CsrAddrWidth-1:0] addr,
                            input logic [stq_pkg::CsrDataWidth-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random(input logic [31:0] rate);
      logic [31:0] dur;
      logic [63:0] now;
      logic [63:0] step;
      if ($urandom_range(0, 99) < 55) begin
         dur = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom;
         now = ($urandom_range(0, 99) < 5) ? {$urandom, $urandom} : timeline;
         send_request(stq_pkg::CmdAdd, 16'($urandom), dur, now);
      end else begin
         step = {32'd0, rate} * 64'($urandom_range(0, 3)) + 64'($urandom_range(0, 2));
         timeline = timeline + step;
         now = ($urandom_range(0, 99) < 5) ? {$urandom, $urandom} : timeline;
         send_request(stq_pkg::CmdInterrupt, 16'($urandom), $urandom, now);
      end
   endtask

   initial begin
      logic [31:0] rates [6];
      logic [31:0] rate;
      reset                     = 1'b1;
      psel                      = 1'b0;
      penable                   = 1'b0;
      pwrite                    = 1'b0;
      paddr                     = '0;
      pwdata                    = '0;
      req_chan.valid            = 1'b0;
      req_chan.command          = stq_pkg::CmdAdd;
      req_chan.event_tag        = '0;
      req_chan.duration_seconds = '0;
      req_chan.now_tick         = '0;
      timeline                  = '0;
      rates = '{32'd1, 32'd0, 32'hFFFF_FFFF, stq_pkg::TicksPerSecondReset, 32'd0, 32'd1000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty queue, wrapped expiry, equal deadlines, a full queue and a full pop.
      send_request(stq_pkg::CmdInterrupt, 16'h0000, 32'h0, 64'h0);
      send_request(stq_pkg::CmdAdd, 16'hFFFF, 32'h0, 64'h0);
      send_request(stq_pkg::CmdAdd, 16'h0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(stq_pkg::CmdInterrupt, 16'h1234, 32'h0, 64'h0);
      for (int i = 1; i <= 15; i++) send_request(stq_pkg::CmdAdd, 16'(i), 32'd1, 64'h0);
      send_request(stq_pkg::CmdAdd, 16'hABCD, 32'd1, 64'h0);
      send_request(stq_pkg::CmdInterrupt, 16'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(stq_pkg::CmdInterrupt, 16'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         rate = (phase == 4) ? $urandom : rates[phase];
         write_csr(RateAddr, rate);
         rates_used++;
         if (phase == 0) write_csr(SpareAddr, 32'h0000_0003);
         timeline = (phase == 2) ? 64'hFFFF_FFF0_0000_0000 : {$urandom, $urandom};
         steady = (phase == 1);
         for (int k = 0; k < PhaseItems; k++) begin
            if (phase == 3 && k == 10) hold_off_go = 1;
            send_random(rate);
         end
         wait_drained();
      end
      steady = 0;

      $display("Sent %0d adds and %0d timer interrupts across %0d counter rates.",
               adds_sent, interrupts_sent, rates_used);
      $display("Compared %0d response transactions against the predicted queue.",
               responses_seen);
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
